@@ rtl/core/dpsr_pkg.sv @@
// Package for the dual paddle serial readout.
// Holds the action codes, the clamp bounds and the per-paddle control struct.
// No dependencies.
package dpsr_pkg;

    localparam int POS_W   = 9;
    localparam int DELTA_W = 10;
    localparam int CODE_W  = 8;
    localparam int IDX_W   = 4;
    localparam int DATA_W  = 5;

    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_STROBE = 2'd1;
    localparam logic [1:0] ACT_READ1  = 2'd2;
    localparam logic [1:0] ACT_READ2  = 2'd3;

    localparam logic [POS_W-1:0] PROTO_LOW  = 9'd38;
    localparam logic [POS_W-1:0] PROTO_HIGH = 9'd228;
    localparam logic [POS_W-1:0] NORM_LOW   = 9'd156;
    localparam logic [POS_W-1:0] NORM_HIGH  = 9'd484;
    localparam logic [POS_W-1:0] POS_RESET  = 9'd340;

    localparam logic [IDX_W-1:0] PROTO_LIMIT = 4'd7;
    localparam logic [IDX_W-1:0] NORM_LIMIT  = 4'd8;

    typedef struct packed {
        logic tick;     // frame tick: move, sample button, build code
        logic latch;    // rising strobe: load shift code, rewind pointer
        logic advance;  // serial read: step the pointer
        logic proto;    // prototype paddle mode
    } t_paddle_ctrl;

endpackage

@@ rtl/core/dpsr_paddle.sv @@
// One paddle: position, button, pending latch byte and serial shifter.
// Depends on dpsr_pkg for widths, bounds and the control struct.
module dpsr_paddle
    import dpsr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_paddle_ctrl              i_ctrl,
    input  logic signed [DELTA_W-1:0] i_delta,
    input  logic                      i_button,
    output logic                      o_serial_bit,
    output logic                      o_pressed
);

    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_pressed;
    logic [CODE_W-1:0] r_pending, n_pending;
    logic [CODE_W-1:0] r_shift;
    logic [IDX_W-1:0]  r_idx;

    logic signed [DELTA_W:0] sum;
    logic signed [DELTA_W:0] lo_s, hi_s;
    logic [POS_W-1:0]        lo, hi, inv;
    logic [IDX_W-1:0]        limit;
    logic                    exhausted;

    // The sum of a 9-bit position and a 10-bit signed delta fits 11 signed bits.
    assign lo   = i_ctrl.proto ? PROTO_LOW : NORM_LOW;
    assign hi   = i_ctrl.proto ? PROTO_HIGH : NORM_HIGH;
    assign lo_s = $signed({2'b00, lo});
    assign hi_s = $signed({2'b00, hi});
    assign sum  = $signed({2'b00, r_pos}) + $signed({i_delta[DELTA_W-1], i_delta});

    always_comb begin
        if (sum < lo_s) begin
            n_pos = lo;
        end else if (sum > hi_s) begin
            n_pos = hi;
        end else begin
            n_pos = sum[POS_W-1:0];
        end
    end

    // Bit reversal of the inverted position over 8 or 9 bits, kept to 8 bits.
    assign inv = ~n_pos;
    always_comb begin
        for (int j = 0; j < CODE_W; j++) begin
            n_pending[j] = i_ctrl.proto ? inv[CODE_W-1-j] : inv[POS_W-1-j];
        end
    end

    assign limit        = i_ctrl.proto ? PROTO_LIMIT : NORM_LIMIT;
    assign exhausted    = (r_idx >= limit);
    assign o_serial_bit = exhausted ? 1'b1 : r_shift[r_idx[2:0]];
    assign o_pressed    = r_pressed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= POS_RESET;
            r_pressed <= 1'b0;
            r_pending <= '0;
            r_shift   <= '0;
            r_idx     <= '0;
        end else begin
            if (i_ctrl.tick) begin
                r_pos     <= n_pos;
                r_pressed <= i_button;
                r_pending <= n_pending;
            end
            if (i_ctrl.latch) begin
                r_shift <= r_pending;
                r_idx   <= '0;
            end else if (i_ctrl.advance && !exhausted) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // A tick always leaves the position inside the window of the mode it ran in.
    a_pos_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_ctrl.tick) && $past(i_rst_n) |->
            ($past(i_ctrl.proto) ? (r_pos >= PROTO_LOW && r_pos <= PROTO_HIGH)
                                 : (r_pos >= NORM_LOW && r_pos <= NORM_HIGH)))
        else $error("paddle position outside clamp window after tick");

    // The pointer never runs past the normal-mode limit.
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= NORM_LIMIT)
        else $error("serial pointer past limit");

endmodule

@@ rtl/core/dual_paddle_serial_readout.sv @@
// A read transaction's result passes through the input register and then the result register.
// Throughput: one transaction per cycle; the input side stalls only when a read
// sits in the input register while the result register is full and stalled.
// Frame ticks and strobe writes produce no result. Reset is synchronous and active
// low; it sets both positions to 340 and clears the mode, flags and paddle state.
// Depends on dpsr_pkg and dpsr_paddle.
module dual_paddle_serial_readout
    import dpsr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [1:0]                i_action,
    input  logic signed [DELTA_W-1:0] i_delta_first,
    input  logic signed [DELTA_W-1:0] i_delta_second,
    input  logic                      i_button_first,
    input  logic                      i_button_second,
    input  logic                      i_strobe_value,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [DATA_W-1:0]         o_read_data,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_data
);

    logic                      r_proto;
    logic                      r_strobe_level;
    logic                      r_s1_valid;
    logic [1:0]                r_action;
    logic signed [DELTA_W-1:0] r_delta_first, r_delta_second;
    logic                      r_button_first, r_button_second;
    logic                      r_strobe_value;
    logic                      r_out_valid;
    logic [DATA_W-1:0]         r_out_data, n_out_data;

    logic         s1_is_read, out_free, s1_advance, s1_fire, latch;
    logic         bit_first, bit_second, pressed_first, pressed_second;
    t_paddle_ctrl ctrl_first, ctrl_second;

    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_data;

    assign s1_is_read = (r_action == ACT_READ1) || (r_action == ACT_READ2);
    assign out_free   = !r_out_valid || !i_stall;
    assign s1_advance = !r_s1_valid || !s1_is_read || out_free;
    assign s1_fire    = r_s1_valid && s1_advance;
    assign o_stall    = !s1_advance;

    assign latch = s1_fire && (r_action == ACT_STROBE) && !r_strobe_level && r_strobe_value;

    always_comb begin
        ctrl_first.tick     = s1_fire && (r_action == ACT_TICK);
        ctrl_first.latch    = latch;
        ctrl_first.proto    = r_proto;
        ctrl_first.advance  = s1_fire && ((r_action == ACT_READ1 && r_proto)
                                       || (r_action == ACT_READ2 && !r_proto));
        ctrl_second.tick    = ctrl_first.tick;
        ctrl_second.latch   = latch;
        ctrl_second.proto   = r_proto;
        ctrl_second.advance = s1_fire && (r_action == ACT_READ2);
    end

    dpsr_paddle u_paddle_first (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl_first),
        .i_delta      (r_delta_first),
        .i_button     (r_button_first),
        .o_serial_bit (bit_first),
        .o_pressed    (pressed_first)
    );

    dpsr_paddle u_paddle_second (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl_second),
        .i_delta      (r_delta_second),
        .i_button     (r_button_second),
        .o_serial_bit (bit_second),
        .o_pressed    (pressed_second)
    );

    // Port layouts: bit 1 serial or button, bit 3 button, bit 4 button or serial.
    always_comb begin
        n_out_data = '0;
        case (r_action)
            ACT_READ1: begin
                n_out_data[1] = r_proto ? bit_first : pressed_first;
            end
            ACT_READ2: begin
                if (r_proto) begin
                    n_out_data[1] = bit_second;
                    n_out_data[3] = pressed_first;
                    n_out_data[4] = pressed_second;
                end else begin
                    n_out_data[1] = bit_first;
                    n_out_data[3] = pressed_second;
                    n_out_data[4] = bit_second;
                end
            end
            default: begin
                n_out_data = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proto        <= 1'b0;
            r_strobe_level <= 1'b0;
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_proto <= i_cfg_data;
            end
            if (s1_fire && (r_action == ACT_STROBE)) begin
                r_strobe_level <= r_strobe_value;
            end
            if (s1_advance) begin
                r_s1_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= s1_fire && s1_is_read;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance && i_valid) begin
            r_action        <= i_action;
            r_delta_first   <= i_delta_first;
            r_delta_second  <= i_delta_second;
            r_button_first  <= i_button_first;
            r_button_second <= i_button_second;
            r_strobe_value  <= i_strobe_value;
        end
        if (out_free) begin
            r_out_data <= n_out_data;
        end
    end

    // A read that leaves the input register always lands in the result register.
    a_read_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && s1_is_read |=> r_out_valid)
        else $error("read transaction lost between stages");

    // Ticks and strobes never create a result when the result register is free.
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && !s1_is_read && out_free |=> !r_out_valid)
        else $error("result produced by a non-read transaction");

    // Upstream is held back only by a read blocked behind a stalled result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && s1_is_read && r_out_valid && i_stall))
        else $error("input stalled without a blocked read");

endmodule

@@ tb/paddle_scoreboard_pkg.sv @@
// Scoreboard for the dual paddle serial readout testbench.
// Tracks paddle state and queues the expected port read bytes.
// Depends on dpsr_pkg.
package paddle_scoreboard_pkg;
    import dpsr_pkg::*;

    typedef struct packed {
        logic [1:0]                action;
        logic signed [DELTA_W-1:0] delta_first;
        logic signed [DELTA_W-1:0] delta_second;
        logic                      button_first;
        logic                      button_second;
        logic                      strobe_value;
    } t_paddle_item;

    class paddle_scoreboard;
        logic                prototype_mode;
        logic [POS_W-1:0]    position[2];
        logic                pressed[2];
        logic [CODE_W-1:0]   pending_code[2];
        logic [CODE_W-1:0]   shift_code[2];
        logic [IDX_W-1:0]    bit_ptr[2];
        logic                strobe_level;
        logic [DATA_W-1:0]   expected_reads[$];
        int                  errors;

        function new();
            prototype_mode = 1'b0;
            strobe_level   = 1'b0;
            errors         = 0;
            for (int p = 0; p < 2; p++) begin
                position[p]     = POS_RESET;
                pressed[p]      = 1'b0;
                pending_code[p] = '0;
                shift_code[p]   = '0;
                bit_ptr[p]      = '0;
            end
        endfunction

        function logic [POS_W-1:0] moved_position(logic [POS_W-1:0] pos,
                                                  logic signed [DELTA_W-1:0] delta);
            int lo;
            int hi;
            int sum;
            lo  = prototype_mode ? int'(PROTO_LOW) : int'(NORM_LOW);
            hi  = prototype_mode ? int'(PROTO_HIGH) : int'(NORM_HIGH);
            sum = int'(pos) + int'(delta);
            if (sum < lo) sum = lo;
            if (sum > hi) sum = hi;
            return sum[POS_W-1:0];
        endfunction

        // Bit reversal of the inverted position over 8 or 9 bits, low byte kept.
        function logic [CODE_W-1:0] latch_code(logic [POS_W-1:0] pos);
            logic [POS_W-1:0] inv;
            logic [POS_W-1:0] bits;
            int               n;
            inv  = ~pos;
            bits = '0;
            n    = prototype_mode ? 8 : 9;
            for (int i = 0; i < n; i++) begin
                bits = {bits[POS_W-2:0], inv[i]};
            end
            return bits[CODE_W-1:0];
        endfunction

        // An exhausted pointer reads as 1 and no longer moves.
        function logic serial_bit(int p, logic [IDX_W-1:0] limit);
            logic b;
            b = 1'b1;
            if (bit_ptr[p] < limit) begin
                b = shift_code[p][bit_ptr[p]];
                bit_ptr[p] = bit_ptr[p] + 1'b1;
            end
            return b;
        endfunction

        function void note_item(t_paddle_item it);
            logic [DATA_W-1:0] data;
            data = '0;
            case (it.action)
                ACT_TICK: begin
                    pressed[0]  = it.button_first;
                    pressed[1]  = it.button_second;
                    position[0] = moved_position(position[0], it.delta_first);
                    position[1] = moved_position(position[1], it.delta_second);
                    pending_code[0] = latch_code(position[0]);
                    pending_code[1] = latch_code(position[1]);
                end
                ACT_STROBE: begin
                    if (!strobe_level && it.strobe_value) begin
                        shift_code[0] = pending_code[0];
                        shift_code[1] = pending_code[1];
                        bit_ptr[0]    = '0;
                        bit_ptr[1]    = '0;
                    end
                    strobe_level = it.strobe_value;
                end
                ACT_READ1: begin
                    if (prototype_mode) data[1] = serial_bit(0, PROTO_LIMIT);
                    else data[1] = pressed[0];
                    expected_reads.push_back(data);
                end
                default: begin
                    if (prototype_mode) begin
                        data[1] = serial_bit(1, PROTO_LIMIT);
                        data[3] = pressed[0];
                        data[4] = pressed[1];
                    end else begin
                        data[1] = serial_bit(0, NORM_LIMIT);
                        data[4] = serial_bit(1, NORM_LIMIT);
                        data[3] = pressed[1];
                    end
                    expected_reads.push_back(data);
                end
            endcase
        endfunction

        function void check_read(logic [DATA_W-1:0] got);
            logic [DATA_W-1:0] want;
            if (expected_reads.size() == 0) begin
                $display("%0t: read_data expected none, actual %h", $time, got);
                errors++;
            end else begin
                want = expected_reads.pop_front();
                if (got !== want) begin
                    $display("%0t: read_data expected %h, actual %h", $time, want, got);
                    errors++;
                end
            end
        endfunction
    endclass

endpackage

@@ tb/dual_paddle_serial_readout_tb.sv @@
// Testbench top for dual_paddle_serial_readout: directed and random port traffic.
// Depends on dpsr_pkg, paddle_scoreboard_pkg and the RTL of the block.
module dual_paddle_serial_readout_tb;
    import dpsr_pkg::*;
    import paddle_scoreboard_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASE_ITEMS = 190;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    logic [1:0]                i_action;
    logic signed [DELTA_W-1:0] i_delta_first;
    logic signed [DELTA_W-1:0] i_delta_second;
    logic                      i_button_first;
    logic                      i_button_second;
    logic                      i_strobe_value;
    logic                      o_valid;
    logic                      i_stall;
    logic [DATA_W-1:0]         o_read_data;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic                      i_cfg_data;

    paddle_scoreboard sb;
    bit tx_quiet;
    bit rx_quiet;
    bit rx_hold_request;
    int cycle_count;

    dual_paddle_serial_readout uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_action        (i_action),
        .i_delta_first   (i_delta_first),
        .i_delta_second  (i_delta_second),
        .i_button_first  (i_button_first),
        .i_button_second (i_button_second),
        .i_strobe_value  (i_strobe_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_read_data     (o_read_data),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    function automatic t_paddle_item make_item(logic [1:0] act, int d1, int d2,
                                               logic b1, logic b2, logic sv);
        t_paddle_item it;
        it.action        = act;
        it.delta_first   = d1[DELTA_W-1:0];
        it.delta_second  = d2[DELTA_W-1:0];
        it.button_first  = b1;
        it.button_second = b2;
        it.strobe_value  = sv;
        return it;
    endfunction

    // Half the deltas span the full range, the rest stay small so that
    // positions wander inside the clamp window.
    function automatic int rand_delta();
        if ($urandom_range(0, 1) == 0) return int'($urandom_range(0, 1023)) - 512;
        return int'($urandom_range(0, 128)) - 64;
    endfunction

    task automatic send(input t_paddle_item it);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 18);
        repeat (gap) @(negedge i_clk) i_valid <= 1'b0;
        @(negedge i_clk);
        i_valid         <= 1'b1;
        i_action        <= it.action;
        i_delta_first   <= it.delta_first;
        i_delta_second  <= it.delta_second;
        i_button_first  <= it.button_first;
        i_button_second <= it.button_second;
        i_strobe_value  <= it.strobe_value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_item(it);
    endtask

    task automatic send_reads(input logic [1:0] act, input int count);
        repeat (count) send(make_item(act, 0, 0, 1'b0, 1'b0, 1'b0));
    endtask

    // Drop valid, let every expected read arrive, then cover the pipeline latency.
    task automatic wait_idle();
        @(negedge i_clk) i_valid <= 1'b0;
        while (sb.expected_reads.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic mode);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.prototype_mode = mode;
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    // Receiver: random stall after each result, plus one long hold on request.
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        i_stall    = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                sb.check_read(o_read_data);
                stall_left = rx_quiet ? 0 : $urandom_range(0, 18);
            end
            @(negedge i_clk);
            if (rx_hold_request) begin
                hold_left       = HOLD_CYCLES;
                rx_hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        int sent;
        int reads;
        sb              = new();
        tx_quiet        = 1'b0;
        rx_quiet        = 1'b0;
        rx_hold_request = 1'b0;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_action        = ACT_TICK;
        i_delta_first   = '0;
        i_delta_second  = '0;
        i_button_first  = 1'b0;
        i_button_second = 1'b0;
        i_strobe_value  = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Normal mode: button-only port one, saturating moves, a repeated
        // strobe that must not relatch, and reads past the last serial bit.
        send_reads(ACT_READ1, 1);
        send(make_item(ACT_TICK, 511, -512, 1'b1, 1'b0, 1'b0));
        send(make_item(ACT_STROBE, 0, 0, 1'b0, 1'b0, 1'b1));
        send(make_item(ACT_STROBE, 0, 0, 1'b0, 1'b0, 1'b1));
        send_reads(ACT_READ2, 9);
        send_reads(ACT_READ1, 1);
        wait_idle();

        // Prototype mode: clamp of positions left over from normal mode,
        // seven serial bits on port one, buttons on port two.
        write_mode(1'b1);
        send(make_item(ACT_TICK, -512, 511, 1'b1, 1'b1, 1'b0));
        send(make_item(ACT_STROBE, 0, 0, 1'b0, 1'b0, 1'b0));
        send(make_item(ACT_STROBE, 0, 0, 1'b0, 1'b0, 1'b1));
        send_reads(ACT_READ1, 8);
        send_reads(ACT_READ2, 1);
        wait_idle();

        for (int phase = 0; phase < 8; phase++) begin
            write_mode(phase[0]);
            tx_quiet = (phase % 3 == 1);
            rx_quiet = (phase % 3 == 2);
            if (phase == 3) begin
                tx_quiet        = 1'b1;
                rx_hold_request = 1'b1;
            end
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 4) == 0) begin
                    send(make_item(2'($urandom_range(0, 3)), rand_delta(), rand_delta(),
                                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1))));
                    sent++;
                end else begin
                    reads = $urandom_range(0, 10);
                    send(make_item(ACT_TICK, rand_delta(), rand_delta(),
                                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1))));
                    send(make_item(ACT_STROBE, 0, 0, 1'b0, 1'b0, 1'b0));
                    send(make_item(ACT_STROBE, 0, 0, 1'b0, 1'b0, 1'b1));
                    repeat (reads) begin
                        send_reads($urandom_range(0, 1) ? ACT_READ2 : ACT_READ1, 1);
                    end
                    sent += 3 + reads;
                end
            end
            wait_idle();
        end

        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
